// ===== src/occupancy_grid_free_select_core_macros.svh =====
// ----------------------------------------------------------------------------
// Occupancy grid assertion macros
// Shared concurrent assertion forms, clocked on i_clk and gated by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_FREE_SELECT_CORE_MACROS_SVH
`define OCCUPANCY_GRID_FREE_SELECT_CORE_MACROS_SVH

// check the consequent in the same cycle as the antecedent
`define OGFS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("occupancy grid assertion failed");

// check the consequent in the cycle after the antecedent
`define OGFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("occupancy grid assertion failed");

`endif

// ===== src/ogfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Occupancy grid package
// Operation codes, configuration register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package ogfs_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned POS_W   = 15;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned EDGE_W  = 8;
    localparam int unsigned DCNT_W  = 4;
    localparam int unsigned SCAN_W  = 8;

    typedef enum logic [2:0] {
        OP_SET     = 3'd0,
        OP_CLR     = 3'd1,
        OP_SELROW  = 3'd2,
        OP_FREECNT = 3'd3,
        OP_SELCOL  = 3'd4,
        OP_INFIELD = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_TILE_EDGE   = 2'd2
    } t_cfg_idx;

endpackage

// ===== src/occupancy_grid_free_select_core.sv =====
// ----------------------------------------------------------------------------
// Occupancy grid free select core
// Tile occupancy bitmap with per-row counts, k-th free row/column select.
// ----------------------------------------------------------------------------
// One transaction at a time. Set, clear, free count and free column select
// first run a 16-step restoring divide of both coordinates by the tile edge,
// then one memory read and, for set and clear, a write-back in the following
// cycle; a column select then scans the row word column by column, up to
// grid_width columns. A free row select scans one row count per cycle out of
// the memory. Row words and counts live in a one-port-read, one-port-write
// memory of MAX_ROWS entries; per-row valid bits return "all free" for rows
// not written since reset, so no clearing pass is needed.
module occupancy_grid_free_select_core #(
    parameter int unsigned MAX_COLUMNS = 64,
    parameter int unsigned MAX_ROWS    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [14:0] o_pixel_pos,
    output logic        o_found,
    output logic [6:0]  o_free_count,
    output logic        o_inside_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned CLW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam logic [8:0] LP_MAXR = 9'(MAX_ROWS);
    localparam logic [6:0] LP_MAXC = 7'(MAX_COLUMNS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_CHK,
        S_SCANR,
        S_SCANC,
        S_FIELD,
        S_OUT
    } t_state;

    t_state r_state;
    ogfs_pkg::t_op r_op;

    logic [6:0] r_cfg_w;
    logic [6:0] r_cfg_h;
    logic [7:0] r_cfg_t;

    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic [15:0] r_ax;
    logic [15:0] r_ay;
    logic [7:0]  r_rx;
    logic [7:0]  r_ry;
    logic [3:0]  r_dcnt;

    logic [RW-1:0]  r_row;
    logic [CLW-1:0] r_col;
    logic [14:0]    r_k;
    logic [7:0]     r_ri;
    logic [7:0]     r_chk_idx;
    logic           r_pend;
    logic [6:0]     r_ci;
    logic [MAX_COLUMNS-1:0] r_word;

    logic [14:0] r_res_pos;
    logic        r_res_found;
    logic [6:0]  r_res_free;
    logic        r_res_in;

    logic        r_out_valid;
    logic [14:0] r_out_pos;
    logic        r_out_found;
    logic [6:0]  r_out_free;
    logic        r_out_in;

    logic [MAX_COLUMNS-1:0] r_mem_bits [MAX_ROWS];
    logic [6:0]             r_mem_cnt  [MAX_ROWS];
    logic [MAX_ROWS-1:0]    r_row_vld;
    logic [MAX_COLUMNS-1:0] r_rd_bits;
    logic [6:0]             r_rd_cnt;
    logic                   r_rd_vld;

    logic [6:0]  w_eff;
    logic [6:0]  h_eff;
    logic [7:0]  t_eff;
    logic        accept;
    logic [15:0] abs_x;
    logic [15:0] abs_y;
    logic [8:0]  rem9_x;
    logic [8:0]  rem9_y;
    logic        ge_x;
    logic        ge_y;
    logic [8:0]  sub_x;
    logic [8:0]  sub_y;
    logic        aligned;
    logic        wr_tile_ok;
    logic        row_ok;
    logic        tgt_ok;
    logic [15:0] tgt_row;
    logic [15:0] tgt_col;
    logic [MAX_COLUMNS-1:0] bits_eff;
    logic [6:0]  cnt_eff;
    logic [MAX_COLUMNS-1:0] col_mask;
    logic        cur_bit;
    logic        rd_en;
    logic [RW-1:0] rd_addr;
    logic        wr_en;
    logic [MAX_COLUMNS-1:0] wr_bits;
    logic [6:0]  wr_cnt;
    logic [7:0]  mul_a;
    logic [15:0] prod;
    logic [14:0] wt;
    logic [14:0] ht;
    logic        row_free;
    logic        col_free;

    assign w_eff = (r_cfg_w == 7'd0) ? 7'd1 : ((r_cfg_w > LP_MAXC) ? LP_MAXC : r_cfg_w);
    assign h_eff = (r_cfg_h == 7'd0) ? 7'd1
                 : (({2'b0, r_cfg_h} > LP_MAXR) ? LP_MAXR[6:0] : r_cfg_h);
    assign t_eff = (r_cfg_t == 8'd0) ? 8'd1 : r_cfg_t;

    assign accept = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);

    assign abs_x = i_x[15] ? 16'(-i_x) : i_x;
    assign abs_y = i_y[15] ? 16'(-i_y) : i_y;

    assign rem9_x = {r_rx, r_ax[15]};
    assign rem9_y = {r_ry, r_ay[15]};
    assign ge_x = (rem9_x >= {1'b0, t_eff});
    assign ge_y = (rem9_y >= {1'b0, t_eff});
    assign sub_x = rem9_x - {1'b0, t_eff};
    assign sub_y = rem9_y - {1'b0, t_eff};

    assign aligned = (r_rx == 8'd0) && (r_ry == 8'd0);
    assign row_ok = (!r_y[15] || (r_ay == 16'd0)) && (r_ay < {9'b0, h_eff});
    assign wr_tile_ok = !aligned
                      || ((!r_x[15] || (r_ax == 16'd0)) && (r_ax < {9'b0, w_eff})
                          && row_ok);

    always_comb begin
        tgt_ok  = 1'b0;
        tgt_row = r_ay;
        tgt_col = 16'd0;
        case (r_op)
            ogfs_pkg::OP_SET, ogfs_pkg::OP_CLR: begin
                tgt_ok  = wr_tile_ok;
                tgt_row = aligned ? r_ay : 16'd0;
                tgt_col = aligned ? r_ax : 16'd0;
            end
            ogfs_pkg::OP_FREECNT: begin
                tgt_ok = row_ok;
            end
            ogfs_pkg::OP_SELCOL: begin
                tgt_ok = row_ok && !r_x[15];
            end
            default: begin
                tgt_ok = 1'b0;
            end
        endcase
    end

    assign bits_eff = r_rd_vld ? r_rd_bits : '0;
    assign cnt_eff  = r_rd_vld ? r_rd_cnt : 7'd0;
    assign cur_bit  = bits_eff[r_col];
    assign row_free = r_pend && (cnt_eff < w_eff);
    assign col_free = (r_ci < w_eff) && !r_word[r_ci[CLW-1:0]];

    always_comb begin
        col_mask = '0;
        col_mask[r_col] = 1'b1;
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = tgt_row[RW-1:0];
        wr_en   = 1'b0;
        wr_bits = bits_eff | col_mask;
        wr_cnt  = cnt_eff + 7'd1;
        case (r_state)
            S_RD: begin
                rd_en = tgt_ok;
            end
            S_SCANR: begin
                rd_en   = (r_ri < {1'b0, h_eff});
                rd_addr = r_ri[RW-1:0];
            end
            S_CHK: begin
                if (r_op == ogfs_pkg::OP_SET) begin
                    wr_en = !cur_bit;
                end else if (r_op == ogfs_pkg::OP_CLR) begin
                    wr_en   = cur_bit;
                    wr_bits = bits_eff & ~col_mask;
                    wr_cnt  = cnt_eff - 7'd1;
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign mul_a = (r_state == S_SCANC) ? {1'b0, r_ci} : r_chk_idx;
    assign prod  = {8'b0, mul_a} * {8'b0, t_eff};
    assign wt    = {8'b0, w_eff} * {7'b0, t_eff};
    assign ht    = {8'b0, h_eff} * {7'b0, t_eff};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_bits[r_row] <= wr_bits;
            r_mem_cnt[r_row]  <= wr_cnt;
        end
        if (rd_en) begin
            r_rd_bits <= r_mem_bits[rd_addr];
            r_rd_cnt  <= r_mem_cnt[rd_addr];
            r_rd_vld  <= r_row_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_w     <= 7'd16;
            r_cfg_h     <= 7'd16;
            r_cfg_t     <= 8'd16;
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (ogfs_pkg::t_cfg_idx'(i_cfg_idx))
                    ogfs_pkg::CFG_GRID_WIDTH:  r_cfg_w <= i_cfg_data[6:0];
                    ogfs_pkg::CFG_GRID_HEIGHT: r_cfg_h <= i_cfg_data[6:0];
                    ogfs_pkg::CFG_TILE_EDGE:   r_cfg_t <= i_cfg_data;
                    default: ;
                endcase
            end

            if (wr_en) begin
                r_row_vld[r_row] <= 1'b1;
            end

            if (r_out_valid && !i_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op        <= ogfs_pkg::t_op'(i_op);
                        r_x         <= i_x;
                        r_y         <= i_y;
                        r_ax        <= abs_x;
                        r_ay        <= abs_y;
                        r_rx        <= 8'd0;
                        r_ry        <= 8'd0;
                        r_dcnt      <= 4'd0;
                        r_k         <= i_y[14:0];
                        r_ri        <= 8'd0;
                        r_pend      <= 1'b0;
                        r_res_pos   <= 15'd0;
                        r_res_found <= 1'b0;
                        r_res_free  <= 7'd0;
                        r_res_in    <= 1'b0;
                        case (ogfs_pkg::t_op'(i_op))
                            ogfs_pkg::OP_SET, ogfs_pkg::OP_CLR,
                            ogfs_pkg::OP_FREECNT, ogfs_pkg::OP_SELCOL: begin
                                r_state <= S_DIV;
                            end
                            ogfs_pkg::OP_SELROW: begin
                                r_state <= i_y[15] ? S_OUT : S_SCANR;
                            end
                            ogfs_pkg::OP_INFIELD: begin
                                r_state <= S_FIELD;
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    r_ax   <= {r_ax[14:0], ge_x};
                    r_ay   <= {r_ay[14:0], ge_y};
                    r_rx   <= ge_x ? sub_x[7:0] : rem9_x[7:0];
                    r_ry   <= ge_y ? sub_y[7:0] : rem9_y[7:0];
                    r_dcnt <= r_dcnt + 4'd1;
                    if (r_dcnt == 4'd15) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_row   <= tgt_row[RW-1:0];
                    r_col   <= tgt_col[CLW-1:0];
                    r_state <= tgt_ok ? S_CHK : S_OUT;
                end
                S_CHK: begin
                    r_word  <= bits_eff;
                    r_k     <= r_x[14:0];
                    r_ci    <= 7'd0;
                    r_state <= S_OUT;
                    if (r_op == ogfs_pkg::OP_FREECNT) begin
                        r_res_free <= (cnt_eff < w_eff) ? (w_eff - cnt_eff) : 7'd0;
                    end else if (r_op == ogfs_pkg::OP_SELCOL) begin
                        r_state <= S_SCANC;
                    end
                end
                S_SCANR: begin
                    if (row_free && (r_k == 15'd0)) begin
                        r_res_found <= 1'b1;
                        r_res_pos   <= prod[14:0];
                        r_pend      <= 1'b0;
                        r_state     <= S_OUT;
                    end else begin
                        if (row_free) begin
                            r_k <= r_k - 15'd1;
                        end
                        if (r_ri < {1'b0, h_eff}) begin
                            r_chk_idx <= r_ri;
                            r_ri      <= r_ri + 8'd1;
                            r_pend    <= 1'b1;
                        end else begin
                            r_pend <= 1'b0;
                            if (!r_pend) begin
                                r_state <= S_OUT;
                            end
                        end
                    end
                end
                S_SCANC: begin
                    r_ci <= r_ci + 7'd1;
                    if (r_ci >= w_eff) begin
                        r_state <= S_OUT;
                    end else if (col_free) begin
                        if (r_k == 15'd0) begin
                            r_res_found <= 1'b1;
                            r_res_pos   <= prod[14:0];
                            r_state     <= S_OUT;
                        end else begin
                            r_k <= r_k - 15'd1;
                        end
                    end
                end
                S_FIELD: begin
                    r_res_in <= !r_x[15] && (r_x[14:0] < wt)
                             && !r_y[15] && (r_y[14:0] < ht);
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_pos   <= r_res_pos;
                        r_out_found <= r_res_found;
                        r_out_free  <= r_res_free;
                        r_out_in    <= r_res_in;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pixel_pos  = r_out_pos;
    assign o_found      = r_out_found;
    assign o_free_count = r_out_free;
    assign o_inside_res = r_out_in;

endmodule

// ===== src/ogfs_checker.sv =====
// ----------------------------------------------------------------------------
// Occupancy grid port checker
// Port-level checks of the free select core, bound to the top level.
// ----------------------------------------------------------------------------
`include "occupancy_grid_free_select_core_macros.svh"

module ogfs_checker #(
    parameter int unsigned MAX_COLUMNS = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [14:0] o_pixel_pos,
    input logic        o_found,
    input logic [6:0]  o_free_count,
    input logic        o_inside_res
);

    `OGFS_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall)
    `OGFS_ASSERT_NOW(a_found_exclusive, o_valid && o_found, (o_free_count == 7'd0) && !o_inside_res)
    `OGFS_ASSERT_NOW(a_free_count_bound, o_valid, o_free_count <= 7'(MAX_COLUMNS))
    `OGFS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_pixel_pos) && $stable(o_found))

endmodule

bind occupancy_grid_free_select_core ogfs_checker #(
    .MAX_COLUMNS(MAX_COLUMNS)
) u_ogfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_pixel_pos (o_pixel_pos),
    .o_found     (o_found),
    .o_free_count(o_free_count),
    .o_inside_res(o_inside_res)
);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Occupancy grid free select core testbench
// Drives set, clear, select and query transactions through the valid/stall
// channels, checking every result field by field: typed directed rows against
// their table answer, others a predictor of the tile bitmap and per-row counts.
// A short table of directed rows comes first, then random phases under several
// register settings and idling patterns, one with a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int HOLD_CYCLES = 600;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [14:0] pos;
        logic        found;
        logic [6:0]  free;
        logic        in_field;
    } t_grid_answer;

    typedef struct {
        logic [2:0]         op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        bit                 typed;
        t_grid_answer       ans;
    } t_stim_row;

    localparam t_grid_answer NO_ANSWER = '0;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_valid    = 1'b0;
    logic [2:0]         i_op       = '0;
    logic signed [15:0] i_x        = '0;
    logic signed [15:0] i_y        = '0;
    logic               i_stall    = 1'b0;
    logic               i_cfg_we   = 1'b0;
    logic [1:0]         i_cfg_idx  = '0;
    logic [7:0]         i_cfg_data = '0;
    logic               o_stall;
    logic               o_valid;
    logic [14:0]        o_pixel_pos;
    logic               o_found;
    logic [6:0]         o_free_count;
    logic               o_inside_res;

    occupancy_grid_free_select_core #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS(MAX_ROWS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_op(i_op),
        .i_x(i_x),
        .i_y(i_y),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_pixel_pos(o_pixel_pos),
        .o_found(o_found),
        .o_free_count(o_free_count),
        .o_inside_res(o_inside_res),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // predicted grid state and register copies
    bit [63:0]  tile_map [MAX_ROWS];
    bit [6:0]   busy_cnt [MAX_ROWS];
    bit [6:0]   cfg_width  = 7'd16;
    bit [6:0]   cfg_height = 7'd16;
    bit [7:0]   cfg_edge   = 8'd16;

    t_grid_answer pending_answers [$];
    t_stim_row    dir_table [25];

    int err_cnt     = 0;
    int sent_cnt    = 0;
    int checked_cnt = 0;
    int setting_cnt = 0;
    int send_idle   = 0;
    int recv_idle   = 0;
    bit hold_ask    = 1'b0;
    bit hold_seen   = 1'b0;
    int hold_left   = 0;

    task automatic flag_mismatch(string msg);
        err_cnt++;
        $display("%0t ns mismatch: %s", $time, msg);
    endtask

    function automatic void grid_dims(output int w, output int h, output int t);
        w = cfg_width;
        if (w < 1) w = 1;
        if (w > MAX_COLUMNS) w = MAX_COLUMNS;
        h = cfg_height;
        if (h < 1) h = 1;
        if (h > MAX_ROWS) h = MAX_ROWS;
        t = (cfg_edge == 0) ? 1 : int'(cfg_edge);
    endfunction

    function automatic t_grid_answer predict_answer(logic [2:0] op, logic signed [15:0] px,
                                                    logic signed [15:0] py);
        int w, h, t, x, y, col, row, k, i;
        bit done;
        t_grid_answer a;
        a = '0;
        x = px;
        y = py;
        done = 1'b0;
        grid_dims(w, h, t);
        case (op)
            ogfs_pkg::OP_SET, ogfs_pkg::OP_CLR: begin
                col = 0;
                row = 0;
                if (x % t == 0 && y % t == 0) begin
                    col = x / t;
                    row = y / t;
                end
                if (col >= 0 && col < w && row >= 0 && row < h) begin
                    if (op == ogfs_pkg::OP_SET && !tile_map[row][col]) begin
                        tile_map[row][col] = 1'b1;
                        busy_cnt[row] = busy_cnt[row] + 7'd1;
                    end else if (op == ogfs_pkg::OP_CLR && tile_map[row][col]) begin
                        tile_map[row][col] = 1'b0;
                        busy_cnt[row] = busy_cnt[row] - 7'd1;
                    end
                end
            end
            ogfs_pkg::OP_SELROW: begin
                k = y;
                if (k >= 0) begin
                    for (i = 0; i < h && !done; i++) begin
                        if (int'(busy_cnt[i]) < w) begin
                            if (k == 0) begin
                                a.pos = 15'(i * t);
                                a.found = 1'b1;
                                done = 1'b1;
                            end
                            k--;
                        end
                    end
                end
            end
            ogfs_pkg::OP_FREECNT: begin
                row = y / t;
                if (row >= 0 && row < h && int'(busy_cnt[row]) < w) begin
                    a.free = 7'(w - int'(busy_cnt[row]));
                end
            end
            ogfs_pkg::OP_SELCOL: begin
                row = y / t;
                k = x;
                if (row >= 0 && row < h && k >= 0) begin
                    for (i = 0; i < w && !done; i++) begin
                        if (!tile_map[row][i]) begin
                            if (k == 0) begin
                                a.pos = 15'(i * t);
                                a.found = 1'b1;
                                done = 1'b1;
                            end
                            k--;
                        end
                    end
                end
            end
            ogfs_pkg::OP_INFIELD: begin
                if (x >= 0 && x < w * t && y >= 0 && y < h * t) a.in_field = 1'b1;
            end
            default: begin
            end
        endcase
        return a;
    endfunction

    task automatic send_item(logic [2:0] op, logic signed [15:0] x, logic signed [15:0] y,
                             bit typed, t_grid_answer fixed);
        t_grid_answer a;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_x     <= x;
        i_y     <= y;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        a = predict_answer(op, x, y);
        pending_answers.insert(pending_answers.size(), typed ? fixed : a);
        sent_cnt++;
    endtask

    task automatic wait_quiet();
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic load_setting(int wd, int ht, int ed);
        int vals [3];
        int r;
        vals = '{wd, ht, ed};
        wait_quiet();
        for (r = 0; r < 3; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 2'(r);
            i_cfg_data <= 8'(vals[r]);
            case (ogfs_pkg::t_cfg_idx'(r))
                ogfs_pkg::CFG_GRID_WIDTH:  cfg_width  = 7'(vals[r]);
                ogfs_pkg::CFG_GRID_HEIGHT: cfg_height = 7'(vals[r]);
                ogfs_pkg::CFG_TILE_EDGE:   cfg_edge   = 8'(vals[r]);
                default: begin
                end
            endcase
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        setting_cnt++;
    endtask

    task automatic fill_phase(int count);
        int w, h, t, r, n, row;
        logic [2:0] op;
        logic signed [15:0] x, y;
        grid_dims(w, h, t);
        for (n = 0; n < count; n++) begin
            r = $urandom_range(99);
            x = 16'($urandom);
            y = 16'($urandom);
            if (r < 34) op = ogfs_pkg::OP_SET;
            else if (r < 48) op = ogfs_pkg::OP_CLR;
            else if (r < 60) op = ogfs_pkg::OP_SELROW;
            else if (r < 70) op = ogfs_pkg::OP_FREECNT;
            else if (r < 84) op = ogfs_pkg::OP_SELCOL;
            else if (r < 95) op = ogfs_pkg::OP_INFIELD;
            else op = 3'($urandom_range(7));
            if ($urandom_range(9) != 0) begin
                case (op)
                    ogfs_pkg::OP_SET, ogfs_pkg::OP_CLR: begin
                        x = 16'((int'($urandom_range(w + 1)) - 1) * t);
                        // crowd the first rows so they fill up
                        if ($urandom_range(1) != 0) row = int'($urandom_range(h + 1)) - 1;
                        else row = int'($urandom_range(1));
                        y = 16'(row * t);
                    end
                    ogfs_pkg::OP_SELROW: begin
                        y = 16'($urandom_range(h + 1));
                    end
                    ogfs_pkg::OP_FREECNT, ogfs_pkg::OP_SELCOL: begin
                        row = int'($urandom_range(h + 1)) - 1;
                        y = 16'(row * t + int'($urandom_range(t - 1)));
                        if (op == ogfs_pkg::OP_SELCOL) x = 16'($urandom_range(w + 1));
                    end
                    ogfs_pkg::OP_INFIELD: begin
                        x = 16'(int'($urandom_range(w * t + 2 * t)) - t);
                        y = 16'(int'($urandom_range(h * t + 2 * t)) - t);
                    end
                    default: begin
                    end
                endcase
            end
            send_item(op, x, y, 1'b0, NO_ANSWER);
        end
    endtask

    // receiver: random stall, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge i_clk) begin
        t_grid_answer want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_answers.size() == 0) begin
                flag_mismatch("result with no transaction outstanding");
            end else begin
                want = pending_answers.pop_front();
                checked_cnt++;
                if (o_pixel_pos !== want.pos)
                    flag_mismatch($sformatf("pixel_pos got %0d want %0d", o_pixel_pos, want.pos));
                if (o_found !== want.found)
                    flag_mismatch($sformatf("found got %0b want %0b", o_found, want.found));
                if (o_free_count !== want.free)
                    flag_mismatch($sformatf("free_count got %0d want %0d", o_free_count,
                                            want.free));
                if (o_inside_res !== want.in_field)
                    flag_mismatch($sformatf("inside_res got %0b want %0b", o_inside_res,
                                            want.in_field));
            end
        end
    end

    initial begin
        #20_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial begin
        int n;
        dir_table = '{
            '{ogfs_pkg::OP_FREECNT, 0,     0,      1'b1, '{15'd0,   1'b0, 7'd16, 1'b0}},
            '{ogfs_pkg::OP_SELROW,  0,     0,      1'b1, '{15'd0,   1'b1, 7'd0,  1'b0}},
            '{ogfs_pkg::OP_SELROW,  0,     15,     1'b1, '{15'd240, 1'b1, 7'd0,  1'b0}},
            '{ogfs_pkg::OP_SELROW,  0,     16,     1'b1, NO_ANSWER},
            '{ogfs_pkg::OP_SELROW,  0,     -32768, 1'b1, NO_ANSWER},
            '{ogfs_pkg::OP_SELCOL,  0,     0,      1'b1, '{15'd0,   1'b1, 7'd0,  1'b0}},
            '{ogfs_pkg::OP_SELCOL,  15,    255,    1'b1, '{15'd240, 1'b1, 7'd0,  1'b0}},
            '{ogfs_pkg::OP_SELCOL,  16,    0,      1'b1, NO_ANSWER},
            '{ogfs_pkg::OP_SELCOL,  -1,    0,      1'b1, NO_ANSWER},
            '{ogfs_pkg::OP_SELCOL,  0,     32767,  1'b1, NO_ANSWER},
            '{ogfs_pkg::OP_INFIELD, 0,     0,      1'b1, '{15'd0,   1'b0, 7'd0,  1'b1}},
            '{ogfs_pkg::OP_INFIELD, 255,   255,    1'b1, '{15'd0,   1'b0, 7'd0,  1'b1}},
            '{ogfs_pkg::OP_INFIELD, 256,   0,      1'b1, NO_ANSWER},
            '{ogfs_pkg::OP_SET,     5,     0,      1'b1, NO_ANSWER},
            '{ogfs_pkg::OP_SET,     16,    16,     1'b1, NO_ANSWER},
            '{ogfs_pkg::OP_SET,     240,   240,    1'b1, NO_ANSWER},
            '{ogfs_pkg::OP_SET,     -16,   0,      1'b1, NO_ANSWER},
            '{ogfs_pkg::OP_SET,     256,   0,      1'b1, NO_ANSWER},
            '{ogfs_pkg::OP_SELCOL,  0,     0,      1'b0, NO_ANSWER},
            '{ogfs_pkg::OP_FREECNT, 0,     -1,     1'b0, NO_ANSWER},
            '{ogfs_pkg::OP_CLR,     16,    16,     1'b1, NO_ANSWER},
            '{ogfs_pkg::OP_CLR,     16,    16,     1'b1, NO_ANSWER},
            '{ogfs_pkg::OP_FREECNT, 0,     16,     1'b0, NO_ANSWER},
            '{OP_SPARE_6,           -1,    -1,     1'b1, NO_ANSWER},
            '{OP_SPARE_7,           32767, 32767,  1'b1, NO_ANSWER}
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 20;
        recv_idle = 52;
        for (n = 0; n < 25; n++) begin
            send_item(dir_table[n].op, dir_table[n].x, dir_table[n].y,
                      dir_table[n].typed, dir_table[n].ans);
        end

        load_setting(64, 64, 1);
        fill_phase(232);
        load_setting(4, 6, 255);
        fill_phase(232);

        send_idle = 52;
        recv_idle = 20;
        load_setting(127, 2, 0);
        fill_phase(232);
        // rows filled at full width now exceed the shrunk width
        load_setting(2, 64, 37);
        fill_phase(232);

        send_idle = 0;
        recv_idle = 0;
        load_setting(0, 1, 8);
        hold_ask = ~hold_ask;
        fill_phase(232);
        load_setting(64, 64, 255);
        fill_phase(232);
        load_setting(12, 20, 7);
        fill_phase(232);

        wait_quiet();
        repeat (100) @(posedge i_clk);

        $display("covered %0d transactions under %0d register settings, %0d results compared",
                 sent_cnt, setting_cnt, checked_cnt);
        $display("idling patterns: sender-heavy, receiver-heavy, none, plus one long hold-off");
        if (err_cnt == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
